### rtl/core/met_pkg.sv
// Shared types, constants and helpers for the Mandelbrot escape-time unit.
package met_pkg;

  localparam int PIXEL_BITS = 12;
  localparam int ITER_BITS  = 16;
  localparam int WORD_BITS  = 32;
  localparam int STEP_BITS  = 31;
  localparam int CFG_IDX_BITS = 3;

  // queue between front and back
  localparam int QDEPTH    = 4;
  localparam int QPTR_BITS = $clog2(QDEPTH);
  localparam int QCNT_BITS = $clog2(QDEPTH + 1);
  localparam int OCC_BITS  = $clog2(QDEPTH + 3);

  localparam logic [CFG_IDX_BITS-1:0] REG_START_RE   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_START_IM   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_STEP_RE    = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_STEP_IM    = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_ITER_LIMIT = 3'd4;

  typedef struct packed {
    logic [PIXEL_BITS-1:0] pixel_x;
    logic [PIXEL_BITS-1:0] pixel_y;
  } pixel_in_t;

  typedef struct packed {
    logic [ITER_BITS-1:0]  iterations;
    logic                  inside_res;
    logic [PIXEL_BITS-1:0] out_x;
    logic [PIXEL_BITS-1:0] out_y;
  } result_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] start_re;
    logic signed [WORD_BITS-1:0] start_im;
    logic [STEP_BITS-1:0]        step_re;
    logic [STEP_BITS-1:0]        step_im;
  } front_cfg_t;

  // one classified item waiting for the iteration engine
  typedef struct packed {
    logic signed [WORD_BITS-1:0] cr;
    logic signed [WORD_BITS-1:0] ci;
    logic [PIXEL_BITS-1:0]       px;
    logic [PIXEL_BITS-1:0]       py;
  } point_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MUL,
    BK_UPD
  } back_state_t;

  localparam logic signed [63:0] WORD_MAX = 64'sd2147483647;
  localparam logic signed [63:0] WORD_MIN = -64'sd2147483648;

  function automatic logic signed [WORD_BITS-1:0] sat_word(input logic signed [63:0] v);
    logic signed [WORD_BITS-1:0] r;
    if (v > WORD_MAX) r = WORD_MAX[WORD_BITS-1:0];
    else if (v < WORD_MIN) r = WORD_MIN[WORD_BITS-1:0];
    else r = v[WORD_BITS-1:0];
    return r;
  endfunction

endpackage

### rtl/core/met_front.sv
// Front end: takes pixel items and maps them to complex points c.
module met_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   accept,
  input  met_pkg::pixel_in_t     pixel,
  input  met_pkg::front_cfg_t    cfg,
  output logic [1:0]             inflight,
  output logic                   push,
  output met_pkg::point_t        point
);

  localparam int PROD_BITS = met_pkg::STEP_BITS + met_pkg::PIXEL_BITS;

  logic                           s1_v;
  logic [PROD_BITS-1:0]           prod_re;
  logic [PROD_BITS-1:0]           prod_im;
  logic [met_pkg::PIXEL_BITS-1:0] s1_x;
  logic [met_pkg::PIXEL_BITS-1:0] s1_y;
  logic                           s2_v;
  met_pkg::point_t                s2;

  logic signed [63:0] sum_re;
  logic signed [63:0] sum_im;

  always_comb begin
    sum_re = 64'(cfg.start_re) + $signed(64'(prod_re));
    sum_im = 64'(cfg.start_im) + $signed(64'(prod_im));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
    end else begin
      s1_v <= accept;
      s2_v <= s1_v;
    end
    if (accept) begin
      prod_re <= PROD_BITS'(cfg.step_re) * PROD_BITS'(pixel.pixel_x);
      prod_im <= PROD_BITS'(cfg.step_im) * PROD_BITS'(pixel.pixel_y);
      s1_x    <= pixel.pixel_x;
      s1_y    <= pixel.pixel_y;
    end
    if (s1_v) begin
      s2.cr <= met_pkg::sat_word(sum_re);
      s2.ci <= met_pkg::sat_word(sum_im);
      s2.px <= s1_x;
      s2.py <= s1_y;
    end
  end

  assign inflight = {1'b0, s1_v} + {1'b0, s2_v};
  assign push     = s2_v;
  assign point    = s2;

endmodule

### rtl/core/met_queue.sv
// Short FIFO of classified points between front and back.
module met_queue (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  met_pkg::point_t               wdata,
  input  logic                          pop,
  output logic                          nonempty,
  output met_pkg::point_t               rdata,
  output logic [met_pkg::QCNT_BITS-1:0] count
);

  met_pkg::point_t                mem [met_pkg::QDEPTH];
  logic [met_pkg::QPTR_BITS-1:0]  wptr;
  logic [met_pkg::QPTR_BITS-1:0]  rptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop)  rptr <= rptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
    if (push) mem[wptr] <= wdata;
  end

  assign nonempty = (count != '0);
  assign rdata    = mem[rptr];

endmodule

### rtl/core/met_back.sv
// Back end: escape-time iteration z = z*z + c, multiply then update.
module met_back #(
  parameter int FRAC_BITS = 27
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  input  met_pkg::point_t               q_point,
  input  logic [met_pkg::ITER_BITS-1:0] iter_limit,
  output logic                          pop,
  output logic                          done,
  output met_pkg::result_t              result
);

  localparam int W          = met_pkg::WORD_BITS;
  localparam int ESC_SHIFT  = 2 * FRAC_BITS + 2;

  met_pkg::back_state_t state, state_next;

  logic signed [W-1:0]            cr, ci, zr, zi;
  logic signed [W-1:0]            zr_next, zi_next;
  logic [met_pkg::PIXEL_BITS-1:0] px, py;
  logic [met_pkg::ITER_BITS-1:0]  cnt, cnt_next;
  logic signed [63:0]             p_rr, p_ii, p_ri;
  logic signed [63:0]             p_rr_next, p_ii_next, p_ri_next;
  logic                           done_next;
  met_pkg::result_t               result_next;

  logic [63:0]        mag;
  logic               escape;
  logic signed [63:0] re2, nr, ni;
  logic               load;
  logic               at_cap;

  always_comb begin
    mag    = 64'(p_rr) + 64'(p_ii);
    escape = ((mag >> ESC_SHIFT) != 64'd0);
    re2    = p_rr - p_ii;
    nr     = (re2 >>> FRAC_BITS) + 64'(cr);
    ni     = (p_ri >>> (FRAC_BITS - 1)) + 64'(ci);
    at_cap = (cnt >= iter_limit);
  end

  always_comb begin
    state_next  = state;
    pop         = 1'b0;
    load        = 1'b0;
    zr_next     = zr;
    zi_next     = zi;
    cnt_next    = cnt;
    p_rr_next   = p_rr;
    p_ii_next   = p_ii;
    p_ri_next   = p_ri;
    done_next   = 1'b0;
    result_next = result;
    case (state)
      met_pkg::BK_IDLE: begin
        if (q_valid) begin
          pop        = 1'b1;
          load       = 1'b1;
          zr_next    = '0;
          zi_next    = '0;
          cnt_next   = '0;
          state_next = met_pkg::BK_MUL;
        end
      end
      met_pkg::BK_MUL: begin
        if (at_cap) begin
          done_next   = 1'b1;
          result_next = '{iterations: cnt, inside_res: 1'b1, out_x: px, out_y: py};
          state_next  = met_pkg::BK_IDLE;
        end else begin
          // 32x32 signed products, sign-extended operands
          p_rr_next  = 64'(zr) * 64'(zr);
          p_ii_next  = 64'(zi) * 64'(zi);
          p_ri_next  = 64'(zr) * 64'(zi);
          state_next = met_pkg::BK_UPD;
        end
      end
      met_pkg::BK_UPD: begin
        if (escape) begin
          done_next   = 1'b1;
          result_next = '{iterations: cnt, inside_res: at_cap, out_x: px, out_y: py};
          state_next  = met_pkg::BK_IDLE;
        end else begin
          zr_next    = met_pkg::sat_word(nr);
          zi_next    = met_pkg::sat_word(ni);
          cnt_next   = cnt + 1'b1;
          state_next = met_pkg::BK_MUL;
        end
      end
      default: state_next = met_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= met_pkg::BK_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
    if (load) begin
      cr <= q_point.cr;
      ci <= q_point.ci;
      px <= q_point.px;
      py <= q_point.py;
    end
    zr     <= zr_next;
    zi     <= zi_next;
    cnt    <= cnt_next;
    p_rr   <= p_rr_next;
    p_ii   <= p_ii_next;
    p_ri   <= p_ri_next;
    result <= result_next;
  end

endmodule

### rtl/core/mandelbrot_escape_time_unit.sv
// Top level of the Mandelbrot escape-time unit: config registers, front, queue, back.
//
//   channel   ports                         handshake
//   ------    ----------------------------  -----------------------------------
//   pixel     start, busy, pixel            item taken when start && !busy
//   result    done, result                  one-cycle strobe, cannot be held off
//   config    cfg_we, cfg_index, cfg_data   write when cfg_we, no wait
//
// The front forms c in its product and sum registers and drops it into a
// 4-entry queue. The back pops in its idle state, then runs each iteration
// as a 32x32 multiply state followed by an add/compare/saturate state: an
// item ends in the multiply state when it reaches the cap (the cap check)
// and in the add/compare/saturate state when it escapes (the escape test);
// done strobes the cycle after that final state.
// Reset restores register defaults and empties the front and queue.
// busy rises when four items are in the front stages and queue together;
// the result side never stalls.
module mandelbrot_escape_time_unit #(
  parameter int FRAC_BITS = 27
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  met_pkg::pixel_in_t                  pixel,
  output logic                                done,
  output met_pkg::result_t                    result,
  input  logic                                cfg_we,
  input  logic [met_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [met_pkg::WORD_BITS-1:0]       cfg_data
);

  // configuration registers
  met_pkg::front_cfg_t            fcfg;
  logic [met_pkg::ITER_BITS-1:0]  iter_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      fcfg.start_re <= -32'sd269777633;
      fcfg.start_im <= -32'sd161061274;
      fcfg.step_re  <= 31'd355205;
      fcfg.step_im  <= 31'd419430;
      iter_limit    <= met_pkg::ITER_BITS'(256);
    end else if (cfg_we) begin
      case (cfg_index)
        met_pkg::REG_START_RE:   fcfg.start_re <= cfg_data;
        met_pkg::REG_START_IM:   fcfg.start_im <= cfg_data;
        met_pkg::REG_STEP_RE:    fcfg.step_re  <= cfg_data[met_pkg::STEP_BITS-1:0];
        met_pkg::REG_STEP_IM:    fcfg.step_im  <= cfg_data[met_pkg::STEP_BITS-1:0];
        met_pkg::REG_ITER_LIMIT: iter_limit    <= cfg_data[met_pkg::ITER_BITS-1:0];
        default: ;  // unknown index: ignored
      endcase
    end
  end

  logic                           accept;
  logic [1:0]                     inflight;
  logic                           push;
  met_pkg::point_t                push_point;
  logic                           pop;
  logic                           q_valid;
  met_pkg::point_t                q_point;
  logic [met_pkg::QCNT_BITS-1:0]  q_count;
  logic [met_pkg::OCC_BITS-1:0]   occupancy;

  // items in the front stages can always land in the queue
  assign occupancy = met_pkg::OCC_BITS'(inflight) + met_pkg::OCC_BITS'(q_count);
  assign busy      = (occupancy >= met_pkg::OCC_BITS'(met_pkg::QDEPTH));
  assign accept    = start && !busy;

  met_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .pixel    (pixel),
    .cfg      (fcfg),
    .inflight (inflight),
    .push     (push),
    .point    (push_point)
  );

  met_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wdata    (push_point),
    .pop      (pop),
    .nonempty (q_valid),
    .rdata    (q_point),
    .count    (q_count)
  );

  met_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_point    (q_point),
    .iter_limit (iter_limit),
    .pop        (pop),
    .done       (done),
    .result     (result)
  );

endmodule

### tb/sv/tb.sv
// Self-checking testbench for the Mandelbrot escape-time unit.
module tb;

  localparam int FRAC         = 27;
  localparam int PIX_MAX      = (1 << met_pkg::PIXEL_BITS) - 1;
  localparam int CYCLE_LIMIT  = 3000000;
  localparam int PRINT_CAP    = 40;
  // escape when |z|^2 >= 4, held with 2*FRAC fraction bits
  localparam logic [63:0] ESCAPE_MAG = 64'd4 << (2 * FRAC);
  localparam logic signed [63:0] SAT_HI = 64'sd2147483647;
  localparam logic signed [63:0] SAT_LO = -64'sd2147483648;

  logic                               clk;
  logic                               rst;
  logic                               start;
  logic                               busy;
  met_pkg::pixel_in_t                 pixel;
  logic                               done;
  met_pkg::result_t                   result;
  logic                               cfg_we;
  logic [met_pkg::CFG_IDX_BITS-1:0]   cfg_index;
  logic [met_pkg::WORD_BITS-1:0]      cfg_data;

  // local copy of the register file, updated on every write
  logic signed [met_pkg::WORD_BITS-1:0] view_re0;
  logic signed [met_pkg::WORD_BITS-1:0] view_im0;
  logic [met_pkg::STEP_BITS-1:0]        pitch_re;
  logic [met_pkg::STEP_BITS-1:0]        pitch_im;
  logic [met_pkg::ITER_BITS-1:0]        iter_cap;

  met_pkg::result_t pending_escapes[$];
  int               mismatch_count = 0;
  int               cycle_count = 0;

  mandelbrot_escape_time_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .pixel     (pixel),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // ---------------------------------------------------------------------------
  // Escape-time predictor
  // ---------------------------------------------------------------------------

  function automatic logic signed [63:0] clip_word(input logic signed [63:0] v);
    if (v > SAT_HI) return SAT_HI;
    if (v < SAT_LO) return SAT_LO;
    return v;
  endfunction

  // Iterates z = z*z + c from z = 0 with floor shifts and word saturation,
  // exactly as the hardware is meant to.
  function automatic met_pkg::result_t predict_escape(
      input logic [met_pkg::PIXEL_BITS-1:0] px,
      input logic [met_pkg::PIXEL_BITS-1:0] py);
    logic signed [63:0] cr, ci, zr, zi, re2, prod_ri;
    logic [63:0]        mag;
    int unsigned        count;
    bit                 escaped;
    met_pkg::result_t   r;
    cr = clip_word(64'(view_re0) + $signed(64'(pitch_re) * 64'(px)));
    ci = clip_word(64'(view_im0) + $signed(64'(pitch_im) * 64'(py)));
    zr = '0;
    zi = '0;
    count = 0;
    escaped = 1'b0;
    while (count < iter_cap && !escaped) begin
      // squares of words fit in 63 bits; their sum needs the unsigned 64th
      mag = $unsigned(zr * zr) + $unsigned(zi * zi);
      if (mag >= ESCAPE_MAG) begin
        escaped = 1'b1;
      end else begin
        re2     = zr * zr - zi * zi;
        prod_ri = zr * zi;
        zr = clip_word((re2 >>> FRAC) + cr);
        zi = clip_word((prod_ri >>> (FRAC - 1)) + ci);
        count++;
      end
    end
    r.iterations = met_pkg::ITER_BITS'(count);
    r.inside_res = (count >= iter_cap);
    r.out_x      = px;
    r.out_y      = py;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking: every strobe is matched against the oldest prediction
  // ---------------------------------------------------------------------------

  task automatic flag_mismatch(input string what, input int got, input int want);
    if (mismatch_count < PRINT_CAP)
      $display("MISMATCH %s: got %0d expected %0d (cycle %0d)", what, got, want, cycle_count);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    met_pkg::result_t want;
    if (!rst && done) begin
      if (pending_escapes.size() == 0) begin
        flag_mismatch("result with nothing pending, out_x", result.out_x, -1);
      end else begin
        want = pending_escapes.pop_front();
        if (result.iterations !== want.iterations)
          flag_mismatch("iterations", result.iterations, want.iterations);
        if (result.inside_res !== want.inside_res)
          flag_mismatch("inside_res", result.inside_res, want.inside_res);
        if (result.out_x !== want.out_x)
          flag_mismatch("out_x", result.out_x, want.out_x);
        if (result.out_y !== want.out_y)
          flag_mismatch("out_y", result.out_y, want.out_y);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers: everything changes on the falling edge
  // ---------------------------------------------------------------------------

  // Holds start until the unit takes the item; start stays high afterwards so
  // back-to-back items need no dead cycle.
  task automatic send_pixel(input int px, input int py);
    start         = 1'b1;
    pixel.pixel_x = met_pkg::PIXEL_BITS'(px);
    pixel.pixel_y = met_pkg::PIXEL_BITS'(py);
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_escapes.push_back(predict_escape(pixel.pixel_x, pixel.pixel_y));
    @(negedge clk);
  endtask

  task automatic idle_cycle();
    start = 1'b0;
    @(negedge clk);
  endtask

  // Wait until every item has come back, then a few cycles of margin.
  task automatic drain_results();
    start = 1'b0;
    while (pending_escapes.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Only called with the unit drained. The mirror applies the same width
  // masking as the hardware; unknown indexes change nothing.
  task automatic write_reg(input logic [met_pkg::CFG_IDX_BITS-1:0] idx,
                           input logic [met_pkg::WORD_BITS-1:0] data);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      met_pkg::REG_START_RE:   view_re0 = data;
      met_pkg::REG_START_IM:   view_im0 = data;
      met_pkg::REG_STEP_RE:    pitch_re = data[met_pkg::STEP_BITS-1:0];
      met_pkg::REG_STEP_IM:    pitch_im = data[met_pkg::STEP_BITS-1:0];
      met_pkg::REG_ITER_LIMIT: iter_cap = data[met_pkg::ITER_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic set_view(input logic [met_pkg::WORD_BITS-1:0] re0,
                          input logic [met_pkg::WORD_BITS-1:0] im0,
                          input logic [met_pkg::WORD_BITS-1:0] dre,
                          input logic [met_pkg::WORD_BITS-1:0] dim,
                          input logic [met_pkg::WORD_BITS-1:0] cap);
    drain_results();
    write_reg(met_pkg::REG_START_RE, re0);
    write_reg(met_pkg::REG_START_IM, im0);
    write_reg(met_pkg::REG_STEP_RE, dre);
    write_reg(met_pkg::REG_STEP_IM, dim);
    write_reg(met_pkg::REG_ITER_LIMIT, cap);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset view: corners of the pixel range, an interior point and a point near
  // the origin, which stays bounded and runs the full default cap.
  task automatic test_reset_defaults();
    send_pixel(0, 0);
    send_pixel(PIX_MAX, PIX_MAX);
    send_pixel(0, PIX_MAX);
    send_pixel(PIX_MAX, 0);
    send_pixel(760, 384);
    send_pixel(12'h555, 12'hAAA);
  endtask

  task automatic test_special_cases();
    // zero cap, written with junk above the field: no iteration at all
    set_view(32'h0000_0000, 32'h0000_0000, 32'h0000_1000, 32'h0000_1000, 32'hFFFF_0000);
    send_pixel(0, 0);
    send_pixel(PIX_MAX, PIX_MAX);
    // c = 2.0 escapes after one step; step words carry a stray top bit
    set_view(32'h1000_0000, 32'h0000_0000, 32'h8000_0000, 32'h8000_0000, 32'd1);
    send_pixel(7, 9);        // escape on the last allowed step: still inside
    drain_results();
    write_reg(met_pkg::REG_ITER_LIMIT, 32'd2);
    send_pixel(PIX_MAX, 0);  // same point, now reported as escaped
    // writes to unused indexes must leave every register alone
    drain_results();
    write_reg(3'd5, $urandom);
    write_reg(3'd6, $urandom);
    write_reg(3'd7, 32'hFFFF_FFFF);
    send_pixel(1, 1);
    // c = -2.0 sits right on the escape circle after one step
    set_view(32'hF000_0000, 32'h0000_0000, 32'd0, 32'd0, 32'd65535);
    send_pixel(0, 0);
  endtask

  task automatic test_saturation();
    // start plus step*pixel overflows the word at its top
    set_view(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd65535);
    send_pixel(PIX_MAX, PIX_MAX);
    send_pixel(0, 0);
    send_pixel(PIX_MAX, 0);
    set_view(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0000, 32'd65535);
    send_pixel(0, PIX_MAX);
    send_pixel(PIX_MAX, 1);
    // origin never escapes: one long run at the largest cap
    set_view(32'h0000_0000, 32'h0000_0000, 32'd0, 32'd0, 32'hFFFF_FFFF);
    send_pixel(0, 0);
  endtask

  // One random window. The sender idles before an item with the given odds,
  // and when hold_mid is set stops halfway until the unit has caught up.
  task automatic run_window(input int n_items, input int idle_pct, input bit hold_mid);
    for (int i = 0; i < n_items; i++) begin
      while ($urandom_range(0, 99) < idle_pct) idle_cycle();
      if (hold_mid && i == n_items / 2) drain_results();
      send_pixel($urandom_range(0, PIX_MAX), $urandom_range(0, PIX_MAX));
    end
  endtask

  // Window around the set: real edge -2.5..-1.5, imaginary edge -1.5..-0.9,
  // steps so that the pixel range spans roughly 2.4..3.4 by 1.2..2.7.
  task automatic random_view(input logic [met_pkg::WORD_BITS-1:0] cap);
    logic [met_pkg::WORD_BITS-1:0] re0, im0;
    re0 = $urandom_range(0, 32'd134217728) - 32'd335544320;
    im0 = $urandom_range(0, 32'd80530637) - 32'd201326592;
    set_view(re0, im0, $urandom_range(80000, 110000), $urandom_range(40000, 90000), cap);
  endtask

  task automatic test_random_views();
    random_view(32'd256);
    run_window(250, 0, 1'b0);
    random_view(32'd32);
    run_window(250, 68, 1'b0);
    random_view(32'd64);
    run_window(250, 29, 1'b1);
    random_view(32'd1);
    run_window(250, 68, 1'b0);
    // raw register noise: mostly saturated c, every data bit toggles
    set_view($urandom, $urandom, $urandom, $urandom, $urandom_range(1, 50) | 32'hA5A5_0000);
    run_window(250, 0, 1'b0);
    random_view(32'd100);
    run_window(250, 29, 1'b0);
  endtask

  initial begin
    rst            = 1'b1;
    start          = 1'b0;
    pixel          = '0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    // reset values of the register file
    view_re0 = -32'sd269777633;
    view_im0 = -32'sd161061274;
    pitch_re = 31'd355205;
    pitch_im = 31'd419430;
    iter_cap = 16'd256;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_defaults();
    test_special_cases();
    test_saturation();
    test_random_views();

    drain_results();
    repeat (20) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("tb failed");
    $finish;
  end

endmodule
